[rtl/core/tdc_pkg.sv]
// tdc_pkg: shared constants, command and status codes, the scan status
// struct and the byte helpers of the tile domain cell.
// No dependencies; used by every file in rtl/core.
`default_nettype none

package tdc_pkg;

  localparam int SET_WORDS_DEF = 4;
  localparam int WORD_W        = 64;
  localparam int MAX_WORDS     = 4;
  localparam int CNT_W         = 9;
  localparam int TILE_W        = 8;
  localparam int RND_W         = 32;
  localparam int CMD_W         = 2;
  localparam int STAT_W        = 2;

  localparam logic [CNT_W-1:0] NUM_TILES_RST = 9'd256;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INTERSECT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COLLAPSE  = 2'd2;

  // cell status codes
  localparam logic [STAT_W-1:0] ST_UNEXPLORED = 2'd0;
  localparam logic [STAT_W-1:0] ST_COLLAPSED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSOLUTION = 2'd2;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [TILE_W-1:0] tile;
    logic [CNT_W-1:0]  total;
  } scan_stat_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) c = c + 4'(b[i]);
    return c;
  endfunction

  // offset of the k-th set bit, counted from the msb (lowest tile id first)
  function automatic logic [2:0] kth8(input logic [7:0] b, input logic [2:0] k);
    logic [2:0] p;
    logic [3:0] seen;
    p    = '0;
    seen = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[7-i]) begin
        if (seen == {1'b0, k}) p = 3'(i);
        seen = seen + 4'd1;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tile_domain_cell.sv]
// Tile domain cell: one solver cell holding the set of still-possible tiles,
// their count and a collapse status. An item is taken only while the
// sequencer is idle. Clear, an intersect that removes nothing and collapse of
// an already decided or empty cell go from idle to S_OUT, which loads the
// result register once it is free. An intersect that removes tiles recounts
// through the byte scanner. Collapse of an open cell runs the serial remainder
// unit on the random value and then the byte scanner until the chosen tile is
// met. A finished result sits in the output register, and the next item is
// taken while it waits.
`default_nettype none

module tile_domain_cell #(
  parameter int SET_WORDS = tdc_pkg::SET_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tdc_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [tdc_pkg::WORD_W-1:0]   in_mask_word0,
  input  wire logic [tdc_pkg::WORD_W-1:0]   in_mask_word1,
  input  wire logic [tdc_pkg::WORD_W-1:0]   in_mask_word2,
  input  wire logic [tdc_pkg::WORD_W-1:0]   in_mask_word3,
  input  wire logic [tdc_pkg::RND_W-1:0]    in_random_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_changed,
  output logic [tdc_pkg::STAT_W-1:0]        out_cell_status,
  output logic [tdc_pkg::TILE_W-1:0]        out_chosen_tile,
  output logic [tdc_pkg::CNT_W-1:0]         out_possible_count,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [tdc_pkg::CNT_W-1:0]    cfg_num_tiles
);

  localparam int TOT  = SET_WORDS * tdc_pkg::WORD_W;
  localparam int ALLW = tdc_pkg::MAX_WORDS * tdc_pkg::WORD_W;
  localparam int CW   = tdc_pkg::CNT_W;
  localparam int SW   = tdc_pkg::STAT_W;
  localparam int TW   = tdc_pkg::TILE_W;
  localparam logic [CW-1:0] TOT_CNT = CW'(TOT);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_OUT} state_t;

  state_t         state_r;
  logic [CW-1:0]  num_tiles_r;
  logic [TOT-1:0] set_r;
  logic [CW-1:0]  count_r;
  logic [SW-1:0]  status_r;
  logic [TW-1:0]  picked_r;
  logic           changed_r;
  logic           sel_r;
  logic           out_valid_r;
  logic           out_changed_r;
  logic [SW-1:0]  out_status_r;
  logic [TW-1:0]  out_tile_r;
  logic [CW-1:0]  out_count_r;

  logic [CW-1:0]   n_sat;
  logic [TOT-1:0]  clear_set;
  logic [ALLW-1:0] mask_all;
  logic [TOT-1:0]  and_set;
  logic            chg;
  logic            in_fire;
  logic            div_start;
  logic            div_done;
  logic [CW-1:0]   div_rem;
  logic            scan_start;
  logic            scan_sel;
  tdc_pkg::scan_stat_t scan_st;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // tile t sits at flat bit TOT-1-t, word 0 on top
  always_comb begin
    n_sat = (num_tiles_r > TOT_CNT) ? TOT_CNT : num_tiles_r;
    for (int i = 0; i < TOT; i++) begin
      clear_set[i] = (CW'(TOT - 1 - i) < n_sat);
    end
    mask_all = {in_mask_word0, in_mask_word1, in_mask_word2, in_mask_word3};
    and_set  = set_r & mask_all[ALLW-1 -: TOT];
    chg      = (and_set != set_r);
  end

  assign div_start  = in_fire && (in_cmd == tdc_pkg::CMD_COLLAPSE) &&
                      (status_r == tdc_pkg::ST_UNEXPLORED) && (count_r != '0);
  assign scan_start = (in_fire && (in_cmd == tdc_pkg::CMD_INTERSECT) && chg) ||
                      ((state_r == S_DIV) && div_done);
  assign scan_sel   = (state_r == S_DIV);

  tdc_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_random_value),
    .divisor  (count_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  tdc_scan #(.SET_WORDS(SET_WORDS)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (scan_start),
    .sel      (scan_sel),
    .k        (div_rem),
    .set_flat (set_r),
    .stat     (scan_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      num_tiles_r   <= tdc_pkg::NUM_TILES_RST;
      set_r         <= '1;
      count_r       <= TOT_CNT;
      status_r      <= tdc_pkg::ST_UNEXPLORED;
      picked_r      <= '0;
      changed_r     <= 1'b0;
      sel_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      out_changed_r <= 1'b0;
      out_status_r  <= tdc_pkg::ST_UNEXPLORED;
      out_tile_r    <= '0;
      out_count_r   <= '0;
    end else begin
      if (cfg_valid) num_tiles_r <= cfg_num_tiles;
      if (out_valid_r && out_ready && (state_r != S_OUT)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_cmd)
              tdc_pkg::CMD_CLEAR: begin
                set_r     <= clear_set;
                count_r   <= n_sat;
                status_r  <= tdc_pkg::ST_UNEXPLORED;
                picked_r  <= '0;
                changed_r <= 1'b0;
                state_r   <= S_OUT;
              end
              tdc_pkg::CMD_INTERSECT: begin
                set_r     <= and_set;
                changed_r <= chg;
                sel_r     <= 1'b0;
                state_r   <= chg ? S_SCAN : S_OUT;
              end
              tdc_pkg::CMD_COLLAPSE: begin
                changed_r <= 1'b0;
                // no solution unless the scan finds a tile
                if (status_r == tdc_pkg::ST_UNEXPLORED) begin
                  status_r <= tdc_pkg::ST_NOSOLUTION;
                  state_r  <= (count_r != '0) ? S_DIV : S_OUT;
                end else begin
                  state_r  <= S_OUT;
                end
              end
              default: begin
                changed_r <= 1'b0;
                state_r   <= S_OUT;
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            sel_r   <= 1'b1;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_st.done) begin
            if (sel_r) begin
              if (scan_st.found) begin
                picked_r <= scan_st.tile;
                status_r <= tdc_pkg::ST_COLLAPSED;
              end
            end else begin
              count_r <= scan_st.total;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_changed_r <= changed_r;
            out_status_r  <= status_r;
            out_tile_r    <= (status_r == tdc_pkg::ST_COLLAPSED) ? picked_r : '0;
            out_count_r   <= count_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_changed        = out_changed_r;
  assign out_cell_status    = out_status_r;
  assign out_chosen_tile    = out_tile_r;
  assign out_possible_count = out_count_r;

endmodule

`default_nettype wire

[rtl/core/tdc_rem.sv]
// tdc_rem: restoring remainder unit, one dividend bit per cycle.
// Depends on tdc_pkg.
`default_nettype none

module tdc_rem (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tdc_pkg::RND_W-1:0]   dividend,
  input  wire logic [tdc_pkg::CNT_W-1:0]   divisor,
  output logic                             done,
  output logic [tdc_pkg::CNT_W-1:0]        rem
);

  localparam int RW = tdc_pkg::RND_W;
  localparam int CW = tdc_pkg::CNT_W;
  localparam int NW = $clog2(RW);

  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;
  logic [RW-1:0] dvd_r;
  logic [CW-1:0] div_r;
  logic [CW-1:0] rem_r;
  logic [CW:0]   trial;
  logic [CW-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[RW-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[RW-2:0], 1'b0};
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[rtl/core/tdc_scan.sv]
// tdc_scan: walks the tile set one byte per cycle in ascending tile order,
// either totalling set bits or locating the k-th set tile.
// Depends on tdc_pkg.
`default_nettype none

module tdc_scan #(
  parameter int SET_WORDS = tdc_pkg::SET_WORDS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                sel,
  input  wire logic [tdc_pkg::CNT_W-1:0]           k,
  input  wire logic [SET_WORDS*tdc_pkg::WORD_W-1:0] set_flat,
  output tdc_pkg::scan_stat_t                      stat
);

  localparam int TOT = SET_WORDS * tdc_pkg::WORD_W;
  localparam int NB  = TOT / 8;
  localparam int IW  = $clog2(NB);
  localparam int CW  = tdc_pkg::CNT_W;
  localparam int TW  = tdc_pkg::TILE_W;

  logic          busy_r;
  logic          sel_r;
  logic          done_r;
  logic          found_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] acc_r;
  logic [TW-1:0] tile_r;

  logic [7:0]    byte_v;
  logic [3:0]    pc;
  logic [2:0]    pos;
  logic          hit;
  logic          last;

  always_comb begin
    byte_v = set_flat[(TOT - 1) - 8 * int'(idx_r) -: 8];
    pc     = tdc_pkg::popcnt8(byte_v);
    pos    = tdc_pkg::kth8(byte_v, acc_r[2:0]);
    hit    = sel_r && (CW'(pc) > acc_r);
    last   = (idx_r == IW'(NB - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      sel_r   <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      idx_r   <= '0;
      acc_r   <= '0;
      tile_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        sel_r   <= sel;
        idx_r   <= '0;
        acc_r   <= sel ? k : '0;
        found_r <= 1'b0;
      end else if (busy_r) begin
        if (hit) begin
          found_r <= 1'b1;
          tile_r  <= TW'({idx_r, pos});
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
        end else begin
          // select mode counts k down, count mode totals up
          acc_r <= sel_r ? acc_r - CW'(pc) : acc_r + CW'(pc);
          idx_r <= idx_r + IW'(1);
          if (last) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    stat.done  = done_r;
    stat.found = found_r;
    stat.tile  = tile_r;
    stat.total = acc_r;
  end

endmodule

`default_nettype wire

[rtl/core/tdc_checker.sv]
// tdc_checker: port-level assertions for the tile domain cell, bound into every
// tile_domain_cell instance. Depends on tdc_pkg and tile_domain_cell.
`default_nettype none

module tdc_checker #(
  parameter int SET_WORDS = tdc_pkg::SET_WORDS_DEF
) (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [tdc_pkg::STAT_W-1:0] out_cell_status,
  input wire logic [tdc_pkg::TILE_W-1:0] out_chosen_tile,
  input wire logic [tdc_pkg::CNT_W-1:0]  out_possible_count
);

  localparam logic [tdc_pkg::CNT_W-1:0] MAX_CNT =
    tdc_pkg::CNT_W'(SET_WORDS * tdc_pkg::WORD_W);

  // a stalled result stays valid and keeps its count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_possible_count))
    else $error("result changed while stalled");

  // the sequencer is busy in the cycle after it takes an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken on consecutive cycles");

  a_tile_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cell_status != tdc_pkg::ST_COLLAPSED) |-> out_chosen_tile == '0)
    else $error("chosen tile set on an undecided cell");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_possible_count <= MAX_CNT)
    else $error("count above set size");

endmodule

bind tile_domain_cell tdc_checker #(.SET_WORDS(SET_WORDS)) u_tdc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_cell_status    (out_cell_status),
  .out_chosen_tile    (out_chosen_tile),
  .out_possible_count (out_possible_count)
);

`default_nettype wire
